// ===== hdl/mbd_pkg.sv =====
// mbd_pkg: shared types, constants and codes of the multi-button debouncer
// used by mbd_lane, mbd_merge and multi_button_debounce; depends on nothing

package mbd_pkg;

   // fixed field widths
   localparam int LANE_MAX       = 16;
   localparam int TIME_W         = 32;
   localparam int DEBOUNCE_W     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;

   // defaults for the top-level parameters
   localparam int NUM_BUTTONS_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = 16'd20;
   localparam logic [LANE_MAX-1:0]   ACTIVE_MASK_RESET = 16'hFF0F;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_MASK   = 2'd1;

   // debouncer phases
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESS   = 2'd1,
      PH_HELD    = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // one scan
   typedef struct packed {
      logic [LANE_MAX-1:0] pin_levels;
      logic [TIME_W-1:0]   time_now;
   } req_type;

   // one result
   typedef struct packed {
      logic [LANE_MAX-1:0] held_state;
      logic [LANE_MAX-1:0] new_presses;
   } rsp_type;

   // what one lane reports for the scan it just took
   typedef struct packed {
      logic held;
      logic fresh;
   } lane_result_type;

endpackage

// ===== hdl/mbd_lane.sv =====
// mbd_lane: one four-phase time-stamp debouncer for a single button
// depends on mbd_pkg for the phase enum and the lane result struct

module mbd_lane #(
   parameter int TIME_BITS = mbd_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               pin_level,
   input  logic                               press_level,
   input  logic [mbd_pkg::DEBOUNCE_W-1:0]     debounce_time,
   input  logic [TIME_BITS-1:0]               time_now,
   output mbd_pkg::lane_result_type           result
);

   localparam int CMP_BITS = (TIME_BITS > mbd_pkg::DEBOUNCE_W) ? TIME_BITS
                                                               : mbd_pkg::DEBOUNCE_W;

   mbd_pkg::phase_type     phase_ff, phase_in;
   logic [TIME_BITS-1:0]   stamp_ff, stamp_in;
   logic [TIME_BITS-1:0]   elapsed;
   logic                   pressed;
   logic                   enough;

   // pin at its active level
   assign pressed = (pin_level == press_level);

   // wrapping elapsed time against the debounce time
   assign elapsed = time_now - stamp_ff;
   assign enough  = (CMP_BITS'(elapsed) >= CMP_BITS'(debounce_time));

   // next phase and time stamp
   always_comb begin
      phase_in = phase_ff;
      stamp_in = stamp_ff;
      if (accept) begin
         case (phase_ff)
            mbd_pkg::PH_IDLE: begin
               if (pressed) begin
                  stamp_in = time_now;
                  phase_in = mbd_pkg::PH_PRESS;
               end
            end
            mbd_pkg::PH_PRESS: begin
               if (!pressed) begin
                  phase_in = mbd_pkg::PH_IDLE;
               end else if (enough) begin
                  phase_in = mbd_pkg::PH_HELD;
               end
            end
            mbd_pkg::PH_HELD: begin
               if (!pressed) begin
                  stamp_in = time_now;
                  phase_in = mbd_pkg::PH_RELEASE;
               end
            end
            mbd_pkg::PH_RELEASE: begin
               if (pressed) begin
                  phase_in = mbd_pkg::PH_HELD;
               end else if (enough) begin
                  phase_in = mbd_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = mbd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // lane outputs: the pressed flag is set exactly in held and release check
   always_comb begin
      result.held  = (phase_in == mbd_pkg::PH_HELD) || (phase_in == mbd_pkg::PH_RELEASE);
      result.fresh = accept && (phase_ff == mbd_pkg::PH_PRESS) && pressed && enough;
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mbd_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // time stamp, written before it is ever read
   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

endmodule

// ===== hdl/mbd_merge.sv =====
// mbd_merge: packs the lane results into one result word and buffers it
// in an output register plus a skid stage; depends on mbd_pkg

module mbd_merge #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  mbd_pkg::lane_result_type  lane_res [NUM_BUTTONS],
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mbd_pkg::rsp_type          rsp_data
);

   mbd_pkg::rsp_type packed_res;
   mbd_pkg::rsp_type out_ff, out_in;
   mbd_pkg::rsp_type skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   // button i lands at bit 15-i, unused buttons read zero
   for (genvar i = 0; i < mbd_pkg::LANE_MAX; i++) begin : g_pack
      if (i < NUM_BUTTONS) begin : g_used
         assign packed_res.held_state[mbd_pkg::LANE_MAX-1-i]  = lane_res[i].held;
         assign packed_res.new_presses[mbd_pkg::LANE_MAX-1-i] = lane_res[i].fresh;
      end else begin : g_unused
         assign packed_res.held_state[mbd_pkg::LANE_MAX-1-i]  = 1'b0;
         assign packed_res.new_presses[mbd_pkg::LANE_MAX-1-i] = 1'b0;
      end
   end

   // output register and skid stage steering
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = packed_res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = packed_res;
         skid_valid_in = 1'b1;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // the skid stage only fills behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   // the skid stage fills only when the result side stalled
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid stage filled without a stall");

   // a newly confirmed press is always also held
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.new_presses & ~out_ff.held_state) == '0))
      else $error("new press reported for a button not held");
`endif

endmodule

// ===== hdl/multi_button_debounce.sv =====
// multi_button_debounce: sixteen-lane button debouncer, top level
// the result of a scan is registered in the output register, or in the skid stage while the output is stalled
// throughput: one scan per cycle while req_stall is low, set by the per-lane phase and stamp registers
// a two-deep output buffer keeps scans flowing while one result is stalled
// reset (synchronous): all lanes idle and released, buffers empty,
// debounce time 20 ms and active-level mask 0xFF0F

module multi_button_debounce #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF,
   parameter int TIME_BITS   = mbd_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mbd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mbd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wen,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [mbd_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [mbd_pkg::LANE_MAX-1:0]   active_ff, active_in;
   logic                           accept;
   logic [TIME_BITS-1:0]           time_now;
   mbd_pkg::lane_result_type       lane_res [NUM_BUTTONS];

   // configuration writes, unknown indexes ignored
   always_comb begin
      debounce_in = debounce_ff;
      active_in   = active_ff;
      if (csr_wen) begin
         case (csr_index)
            mbd_pkg::CSR_DEBOUNCE_TIME: debounce_in = csr_wdata;
            mbd_pkg::CSR_ACTIVE_MASK:   active_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mbd_pkg::DEBOUNCE_RESET;
         active_ff   <= mbd_pkg::ACTIVE_MASK_RESET;
      end else begin
         debounce_ff <= debounce_in;
         active_ff   <= active_in;
      end
   end

   // scan transfer
   assign accept   = req_valid && !req_stall;
   assign time_now = req_data.time_now[TIME_BITS-1:0];

   // one debouncer per button
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      mbd_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock         (clock),
         .reset         (reset),
         .accept        (accept),
         .pin_level     (req_data.pin_levels[i]),
         .press_level   (active_ff[i]),
         .debounce_time (debounce_ff),
         .time_now      (time_now),
         .result        (lane_res[i])
      );
   end

   // pack and buffer the result
   mbd_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .lane_res  (lane_res),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/multi_button_debounce_test.sv =====
// multi_button_debounce_test: self-checking testbench for the sixteen-lane button debouncer
// holds its own per-lane debounce predictor; the scans are directed and then random
// depends on mbd_pkg and multi_button_debounce
`timescale 1ns / 1ps

module multi_button_debounce_test;

   typedef logic [mbd_pkg::LANE_MAX-1:0]   lanes_type;
   typedef logic [mbd_pkg::TIME_W-1:0]     stamp_type;
   typedef logic [mbd_pkg::DEBOUNCE_W-1:0] debounce_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER = 120;
   // register indexes with no register behind them
   localparam logic [mbd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [mbd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mbd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mbd_pkg::rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic [mbd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mbd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and its copy of the registers
   mbd_pkg::phase_type lane_phase [mbd_pkg::LANE_MAX];
   stamp_type lane_stamp [mbd_pkg::LANE_MAX];
   logic lane_held [mbd_pkg::LANE_MAX];
   debounce_type cfg_debounce = mbd_pkg::DEBOUNCE_RESET;
   lanes_type cfg_active_mask = mbd_pkg::ACTIVE_MASK_RESET;

   mbd_pkg::req_type scan_queue [$];
   mbd_pkg::rsp_type predicted_results [$];

   // stimulus stream
   stamp_type stream_ms;
   lanes_type target_levels;

   int scans_sent = 0;
   int results_seen = 0;
   int confirmed_presses = 0;
   int mismatches = 0;
   int settings_used = 0;
   int idle_cycles = 0;
   bit idling_on = 1'b1;
   bit send_bursty = 1'b1;
   bit recv_bursty = 1'b1;
   bit pressure_done = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;

   multi_button_debounce dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // one scan through all lanes; updates lane state and returns the result
   function automatic mbd_pkg::rsp_type debounce_scan(input mbd_pkg::req_type scan);
      mbd_pkg::rsp_type res;
      logic pressed;
      stamp_type elapsed;
      res = '0;
      for (int i = 0; i < mbd_pkg::LANE_MAX; i++) begin
         pressed = (scan.pin_levels[i] == cfg_active_mask[i]);
         elapsed = scan.time_now - lane_stamp[i];
         case (lane_phase[i])
            mbd_pkg::PH_IDLE: begin
               if (pressed) begin
                  lane_stamp[i] = scan.time_now;
                  lane_phase[i] = mbd_pkg::PH_PRESS;
               end
            end
            mbd_pkg::PH_PRESS: begin
               if (!pressed) begin
                  lane_phase[i] = mbd_pkg::PH_IDLE;
               end else if (elapsed >= stamp_type'(cfg_debounce)) begin
                  lane_held[i] = 1'b1;
                  lane_phase[i] = mbd_pkg::PH_HELD;
                  res.new_presses[15-i] = 1'b1;
               end
            end
            mbd_pkg::PH_HELD: begin
               if (!pressed) begin
                  lane_stamp[i] = scan.time_now;
                  lane_phase[i] = mbd_pkg::PH_RELEASE;
               end
            end
            default: begin
               if (pressed) begin
                  lane_phase[i] = mbd_pkg::PH_HELD;
               end else if (elapsed >= stamp_type'(cfg_debounce)) begin
                  lane_held[i] = 1'b0;
                  lane_phase[i] = mbd_pkg::PH_IDLE;
               end
            end
         endcase
         res.held_state[15-i] = lane_held[i];
      end
      return res;
   endfunction

   initial begin
      for (int i = 0; i < mbd_pkg::LANE_MAX; i++) begin
         lane_phase[i] = mbd_pkg::PH_IDLE;
         lane_stamp[i] = '0;
         lane_held[i] = 1'b0;
      end
   end

   // scan driver: offers queued scans, predicts each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(debounce_scan(req_data));
            scans_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling_on && send_bursty && $urandom_range(0, 5) == 0) begin
               gap_left = int'($urandom_range(1, 12)) - 1;
               req_valid <= 1'b0;
            end else if (scan_queue.size() > 0) begin
               req_data <= scan_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if ($urandom_range(0, 49) == 0) send_bursty = !send_bursty;
      end
   end

   // result monitor: checks each transfer, drives the stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            confirmed_presses += $countones(rsp_data.new_presses);
            if (predicted_results.size() == 0) begin
               $error("result with nothing expected: held_state %h new_presses %h",
                      rsp_data.held_state, rsp_data.new_presses);
               mismatches++;
            end else begin
               mbd_pkg::rsp_type want;
               want = predicted_results.pop_front();
               if (rsp_data.held_state !== want.held_state) begin
                  $error("held_state expected %h actual %h",
                         want.held_state, rsp_data.held_state);
                  mismatches++;
               end
               if (rsp_data.new_presses !== want.new_presses) begin
                  $error("new_presses expected %h actual %h",
                         want.new_presses, rsp_data.new_presses);
                  mismatches++;
               end
            end
         end
         // one long hold-off so the output buffer fills and the input stalls
         if (!pressure_done && results_seen >= HOLD_OFF_AFTER) begin
            pressure_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && recv_bursty && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(1, 12)) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 49) == 0) recv_bursty = !recv_bursty;
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_scan(input lanes_type pins, input stamp_type stamp);
      mbd_pkg::req_type scan;
      scan.pin_levels = pins;
      scan.time_now = stamp;
      scan_queue.push_back(scan);
   endtask

   // well-formed press/release sequences with bounce, plus some raw noise
   task automatic queue_scans(input int count, input int max_step);
      mbd_pkg::req_type scan;
      lanes_type bounce;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 15) == 0) begin
            scan.pin_levels = lanes_type'($urandom);
            scan.time_now = $urandom;
         end else begin
            if ($urandom_range(0, 39) == 0) stream_ms += $urandom;
            else stream_ms += $urandom_range(0, max_step);
            for (int b = 0; b < mbd_pkg::LANE_MAX; b++) begin
               if ($urandom_range(0, 19) == 0) target_levels[b] = ~target_levels[b];
            end
            bounce = '0;
            if ($urandom_range(0, 3) == 0) begin
               bounce = lanes_type'($urandom) & lanes_type'($urandom) & lanes_type'($urandom);
            end
            scan.pin_levels = target_levels ^ bounce;
            scan.time_now = stream_ms;
         end
         scan_queue.push_back(scan);
      end
   endtask

   // returns at a falling edge once every scan has been sent and checked
   task automatic wait_drained();
      do @(negedge clock);
      while (scan_queue.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [mbd_pkg::CSR_INDEX_W-1:0] index,
                            input logic [mbd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (index)
         mbd_pkg::CSR_DEBOUNCE_TIME: cfg_debounce = value;
         mbd_pkg::CSR_ACTIVE_MASK: cfg_active_mask = value;
         default: ;
      endcase
      settings_used++;
   endtask

   task automatic random_phase(input debounce_type debounce,
                               input lanes_type mask,
                               input stamp_type start_ms,
                               input int count, input int max_step);
      wait_drained();
      write_reg(mbd_pkg::CSR_DEBOUNCE_TIME, debounce);
      write_reg(mbd_pkg::CSR_ACTIVE_MASK, mask);
      @(negedge clock);
      stream_ms = start_ms;
      target_levels = lanes_type'($urandom);
      queue_scans(count, max_step);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: exact threshold, bounce on both checks, time wrap
      push_scan(16'h0000, 32'd0);
      push_scan(16'h0000, 32'd19);
      push_scan(16'h0000, 32'd20);
      push_scan(16'hFFFF, 32'd25);
      push_scan(16'h0000, 32'd30);
      push_scan(16'hFFFF, 32'd40);
      push_scan(16'hFFFF, 32'd59);
      push_scan(16'hFFFF, 32'd60);
      push_scan(16'h5555, 32'd61);
      push_scan(16'h5555, 32'hFFFF_FFF0);
      push_scan(16'hAAAA, 32'hFFFF_FFF0);
      push_scan(16'hAAAA, 32'hFFFF_FFFF);
      push_scan(16'hAAAA, 32'h0000_0003);
      push_scan(16'hAAAA, 32'h0000_0004);

      // zero debounce time; writes to spare indexes must change nothing
      wait_drained();
      write_reg(mbd_pkg::CSR_DEBOUNCE_TIME, 16'd0);
      write_reg(CSR_SPARE_2, 16'hFFFF);
      write_reg(CSR_SPARE_3, 16'h1234);
      @(negedge clock);
      push_scan(16'hFFFF, 32'd100);
      push_scan(16'hFFFF, 32'd100);
      push_scan(16'h0000, 32'd100);
      push_scan(16'h0000, 32'd100);
      push_scan(16'hFFFF, 32'd200);
      push_scan(16'h0000, 32'd200);
      push_scan(16'hFFFF, 32'hFFFF_FFFF);
      push_scan(16'hFFFF, 32'hFFFF_FFFF);

      // random sequences under several settings
      random_phase(16'd5, 16'hFFFF, $urandom, 170, 3);
      random_phase(16'd0, 16'h0000, $urandom, 150, 2);
      random_phase(16'hFFFF, lanes_type'($urandom), 32'hFFFF_0000, 150, 9000);
      wait_drained();
      idling_on = 1'b0;
      random_phase(debounce_type'($urandom_range(1, 40)), mbd_pkg::ACTIVE_MASK_RESET,
                   $urandom, 160, 6);

      wait_drained();
      repeat (4) @(posedge clock);
      $display("checked %0d scans under %0d register writes, %0d presses confirmed",
               results_seen, settings_used, confirmed_presses);
      $display("receiver hold-off of %0d cycles exercised: %0d", HOLD_OFF_CYCLES, pressure_done);
      if (mismatches == 0 && predicted_results.size() == 0 && scans_sent == results_seen) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== multi_button_debounce.f =====
hdl/mbd_pkg.sv
hdl/mbd_lane.sv
hdl/mbd_merge.sv
hdl/multi_button_debounce.sv
dv/multi_button_debounce_test.sv
